// ===== rtl/srdd_pkg.sv =====
// Package for the sample record delta decoder.
// Holds item types, result kinds, command codes and queue sizes.
// No dependencies.
package srdd_pkg;

	localparam int CMD_DEPTH = 4;
	localparam int CMD_AW    = $clog2(CMD_DEPTH);
	localparam int OUT_DEPTH = 4;
	localparam int OUT_AW    = $clog2(OUT_DEPTH);

	localparam logic [2:0] KIND_SAMPLE    = 3'd0;
	localparam logic [2:0] KIND_END_OK    = 3'd1;
	localparam logic [2:0] KIND_BAD_TYPE  = 3'd2;
	localparam logic [2:0] KIND_TRUNC     = 3'd3;
	localparam logic [2:0] KIND_OVERFLOW  = 3'd4;

	localparam logic [7:0] SAMPLES_TYPE   = 8'd2;

	localparam logic [3:0] OP_SET_BREF     = 4'd0;
	localparam logic [3:0] OP_SET_BLOG     = 4'd1;
	localparam logic [3:0] OP_SET_BTIME    = 4'd2;
	localparam logic [3:0] OP_SET_DREF     = 4'd3;
	localparam logic [3:0] OP_SET_DLOG     = 4'd4;
	localparam logic [3:0] OP_SET_DTIME    = 4'd5;
	localparam logic [3:0] OP_SAMPLE_BASE  = 4'd6;
	localparam logic [3:0] OP_SAMPLE_DELTA = 4'd7;
	localparam logic [3:0] OP_END_OK       = 4'd8;
	localparam logic [3:0] OP_ERROR        = 4'd9;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_record;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [63:0]        series_ref;
		logic [63:0]        log_id;
		logic signed [63:0] timestamp;
		logic [63:0]        value_bits;
		logic               last_of_item;
	} out_item_t;

	typedef struct packed {
		logic [3:0]  op;
		logic [63:0] word;
		logic        end_mark;
		logic [2:0]  kind;
	} cmd_t;

endpackage

// ===== rtl/srdd_front.sv =====
// Front end: parses record bytes into words, varint deltas and commands.
// Depends on srdd_pkg.
module srdd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  srdd_pkg::in_item_t item,
	output logic             cmd_valid,
	output srdd_pkg::cmd_t   cmd
);
	import srdd_pkg::*;

	localparam logic [3:0] PH_TYPE      = 4'd0;
	localparam logic [3:0] PH_BASE_REF  = 4'd1;
	localparam logic [3:0] PH_BASE_LOG  = 4'd2;
	localparam logic [3:0] PH_BASE_TIME = 4'd3;
	localparam logic [3:0] PH_BASE_VAL  = 4'd4;
	localparam logic [3:0] PH_D_REF     = 4'd5;
	localparam logic [3:0] PH_D_LOG     = 4'd6;
	localparam logic [3:0] PH_D_TIME    = 4'd7;
	localparam logic [3:0] PH_VAL       = 4'd8;

	logic [3:0]  phase_q, phase_d;
	logic [3:0]  count_q, count_d;
	logic [63:0] acc_q, acc_d;
	logic        drop_q, drop_d;

	logic [7:0]  b;
	logic        e;
	logic [63:0] acc_shift, acc_or, zz;
	logic [5:0]  shamt;
	logic        word_done, fixed_ph, varint_ph;
	logic        err;
	logic [2:0]  err_kind;

	assign b         = item.data_byte;
	assign e         = item.end_of_record;
	assign acc_shift = {acc_q[55:0], b};
	assign shamt     = 6'(7 * count_q);
	assign acc_or    = acc_q | (64'(b[6:0]) << shamt);
	assign zz        = (acc_or >> 1) ^ {64{acc_or[0]}};
	assign word_done = (count_q == 4'd7);
	assign fixed_ph  = (phase_q == PH_BASE_REF) || (phase_q == PH_BASE_LOG) ||
	                   (phase_q == PH_BASE_TIME) || (phase_q == PH_BASE_VAL) ||
	                   (phase_q == PH_VAL);
	assign varint_ph = (phase_q == PH_D_REF) || (phase_q == PH_D_LOG) ||
	                   (phase_q == PH_D_TIME);

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		acc_d     = acc_q;
		drop_d    = drop_q;
		cmd_valid = 1'b0;
		cmd       = '0;
		err       = 1'b0;
		err_kind  = KIND_TRUNC;
		if (take) begin
			priority if (drop_q) begin
				if (e) begin
					drop_d  = 1'b0;
					phase_d = PH_TYPE;
				end
			end else if (phase_q == PH_TYPE) begin
				if (b != SAMPLES_TYPE) begin
					err      = 1'b1;
					err_kind = KIND_BAD_TYPE;
				end else if (e) begin
					cmd_valid = 1'b1;
					cmd.op    = OP_END_OK;
				end else begin
					phase_d = PH_BASE_REF;
					count_d = '0;
					acc_d   = '0;
				end
			end else if (fixed_ph) begin
				if (!word_done) begin
					count_d = count_q + 4'd1;
					acc_d   = acc_shift;
					err     = e;
				end else begin
					count_d  = '0;
					acc_d    = '0;
					cmd.word = acc_shift;
					unique case (phase_q)
						PH_BASE_REF: begin
							cmd.op    = OP_SET_BREF;
							cmd_valid = !e;
							err       = e;
							phase_d   = PH_BASE_LOG;
						end
						PH_BASE_LOG: begin
							cmd.op    = OP_SET_BLOG;
							cmd_valid = !e;
							err       = e;
							phase_d   = PH_BASE_TIME;
						end
						PH_BASE_TIME: begin
							cmd.op    = OP_SET_BTIME;
							cmd_valid = !e;
							err       = e;
							phase_d   = PH_BASE_VAL;
						end
						default: begin
							cmd.op       = (phase_q == PH_BASE_VAL) ? OP_SAMPLE_BASE
							                                        : OP_SAMPLE_DELTA;
							cmd.end_mark = e;
							cmd_valid    = 1'b1;
							phase_d      = e ? PH_TYPE : PH_D_REF;
						end
					endcase
				end
			end else if (varint_ph) begin
				if (count_q == 4'd9 && b[7]) begin
					err      = 1'b1;
					err_kind = KIND_OVERFLOW;
				end else if (b[7]) begin
					count_d = count_q + 4'd1;
					acc_d   = acc_or;
					err     = e;
				end else if (e) begin
					err = 1'b1;
				end else begin
					count_d   = '0;
					acc_d     = '0;
					cmd_valid = 1'b1;
					cmd.word  = zz;
					unique case (phase_q)
						PH_D_REF: begin
							cmd.op  = OP_SET_DREF;
							phase_d = PH_D_LOG;
						end
						PH_D_LOG: begin
							cmd.op  = OP_SET_DLOG;
							phase_d = PH_D_TIME;
						end
						default: begin
							cmd.op  = OP_SET_DTIME;
							phase_d = PH_VAL;
						end
					endcase
				end
			end else begin
				phase_d = PH_TYPE;
			end
			if (err) begin
				cmd_valid = 1'b1;
				cmd       = '0;
				cmd.op    = OP_ERROR;
				cmd.kind  = err_kind;
				phase_d   = PH_TYPE;
				count_d   = '0;
				acc_d     = '0;
				drop_d    = !e;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			count_q <= '0;
			acc_q   <= '0;
			drop_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			acc_q   <= acc_d;
			drop_q  <= drop_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) drop_q |-> phase_q == PH_TYPE)
		else $error("dropping outside type phase");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= 4'd9)
		else $error("byte count out of range");

endmodule

// ===== rtl/srdd_cmd_queue.sv =====
// Short command queue between front end and back end.
// Depends on srdd_pkg.
module srdd_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  srdd_pkg::cmd_t wdata,
	output logic           full,
	input  logic           rd,
	output logic           valid,
	output srdd_pkg::cmd_t rdata
);
	import srdd_pkg::*;

	cmd_t            mem_q [CMD_DEPTH];
	logic [CMD_AW-1:0] wp_q, rp_q;
	logic [CMD_AW:0]   cnt_q;
	logic              do_rd;

	assign full  = (cnt_q == (CMD_AW+1)'(CMD_DEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rp_q];
	assign do_rd = rd && valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (CMD_AW+1)'(wr) - (CMD_AW+1)'(do_rd);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(wr && full))
		else $error("command queue overrun");

endmodule

// ===== rtl/srdd_back.sv =====
// Back end: holds base words and deltas, builds results, result queue.
// Depends on srdd_pkg.
module srdd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  srdd_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	output logic              empty,
	input  logic              pop,
	output srdd_pkg::out_item_t result
);
	import srdd_pkg::*;

	logic [63:0] bref_q, blog_q, btime_q, dref_q, dlog_q, dtime_q;
	logic        second_q, second_d;

	out_item_t         oq_q [OUT_DEPTH];
	logic [OUT_AW-1:0] wp_q, rp_q;
	logic [OUT_AW:0]   cnt_q;
	logic              space, wr, do_rd, is_base;
	out_item_t         res;
	logic [63:0]       sum_ref, sum_log, sum_time;

	assign space    = (cnt_q != (OUT_AW+1)'(OUT_DEPTH));
	assign empty    = (cnt_q == '0);
	assign result   = oq_q[rp_q];
	assign do_rd    = pop && !empty;
	assign is_base  = (cmd.op == OP_SAMPLE_BASE);
	assign sum_ref  = is_base ? bref_q  : bref_q  + dref_q;
	assign sum_log  = is_base ? blog_q  : blog_q  + dlog_q;
	assign sum_time = is_base ? btime_q : btime_q + dtime_q;

	always_comb begin
		wr       = 1'b0;
		cmd_pop  = 1'b0;
		second_d = second_q;
		res      = '0;
		if (cmd_valid) begin
			unique case (cmd.op)
				OP_SET_BREF, OP_SET_BLOG, OP_SET_BTIME,
				OP_SET_DREF, OP_SET_DLOG, OP_SET_DTIME: begin
					cmd_pop = 1'b1;
				end
				OP_SAMPLE_BASE, OP_SAMPLE_DELTA: begin
					if (space) begin
						wr = 1'b1;
						if (second_q) begin
							res.kind         = KIND_END_OK;
							res.last_of_item = 1'b1;
							cmd_pop          = 1'b1;
							second_d         = 1'b0;
						end else begin
							res.kind         = KIND_SAMPLE;
							res.series_ref   = sum_ref;
							res.log_id       = sum_log;
							res.timestamp    = sum_time;
							res.value_bits   = cmd.word;
							res.last_of_item = !cmd.end_mark;
							cmd_pop          = !cmd.end_mark;
							second_d         = cmd.end_mark;
						end
					end
				end
				OP_END_OK: begin
					if (space) begin
						wr               = 1'b1;
						res.kind         = KIND_END_OK;
						res.last_of_item = 1'b1;
						cmd_pop          = 1'b1;
					end
				end
				OP_ERROR: begin
					if (space) begin
						wr               = 1'b1;
						res.kind         = cmd.kind;
						res.last_of_item = 1'b1;
						cmd_pop          = 1'b1;
					end
				end
				default: begin
					cmd_pop = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			unique case (cmd.op)
				OP_SET_BREF:  bref_q  <= cmd.word;
				OP_SET_BLOG:  blog_q  <= cmd.word;
				OP_SET_BTIME: btime_q <= cmd.word;
				OP_SET_DREF:  dref_q  <= cmd.word;
				OP_SET_DLOG:  dlog_q  <= cmd.word;
				OP_SET_DTIME: dtime_q <= cmd.word;
				default: ;
			endcase
		end
		if (wr) begin
			oq_q[wp_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
			wp_q     <= '0;
			rp_q     <= '0;
			cnt_q    <= '0;
		end else begin
			second_q <= second_d;
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (OUT_AW+1)'(wr) - (OUT_AW+1)'(do_rd);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> cmd_valid && cmd.end_mark &&
		(cmd.op == OP_SAMPLE_BASE || cmd.op == OP_SAMPLE_DELTA))
		else $error("pending end status without its sample command");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (OUT_AW+1)'(OUT_DEPTH))
		else $error("result queue overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		wr && res.kind == KIND_SAMPLE && cmd.end_mark |=> second_q)
		else $error("end status lost after final sample");

endmodule

// ===== rtl/sample_record_delta_decoder.sv =====
// Top level of the sample record delta decoder.
// Depends on srdd_pkg, srdd_front, srdd_cmd_queue and srdd_back.
//
//   channel   handshake          payload
//   input     push / full        item   (data_byte, end_of_record)
//   result    empty / pop        result (kind, series_ref, log_id,
//                                        timestamp, value_bits, last_of_item)
//
// One byte is accepted per cycle unless full is high; the front end parses it
// in that cycle. The back end writes one result per cycle while the result
// queue has room; the end-marked value byte gives a sample, then end status.
// A 4-entry command queue and a 4-entry result queue sit between the parts.
// full rises when the command queue is full; the back end holds while the
// result queue is full. Reset empties both queues and expects a type byte.
module sample_record_delta_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  srdd_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output srdd_pkg::out_item_t result
);
	import srdd_pkg::*;

	logic take, f_valid, q_valid, q_pop;
	cmd_t f_cmd, q_cmd;

	assign take = push && !full;

	srdd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (item),
		.cmd_valid (f_valid),
		.cmd       (f_cmd)
	);

	srdd_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_valid),
		.wdata  (f_cmd),
		.full   (full),
		.rd     (q_pop),
		.valid  (q_valid),
		.rdata  (q_cmd)
	);

	srdd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_pop   (q_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for sample_record_delta_decoder: streams sample records byte by byte,
// predicts the decoded samples and status results, and checks every result popped from the block.
// Depends on srdd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module testbench;
	import srdd_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int RANDOM_BYTES = 800;

	typedef enum logic [3:0] {
		ST_TYPE, ST_BASE_REF, ST_BASE_LOG, ST_BASE_TIME, ST_BASE_VAL,
		ST_DREF, ST_DLOG, ST_DTIME, ST_VAL
	} parse_state_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_item_t  item = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_item_t result;

	in_item_t     pending_items[$];
	out_item_t    expected_results[$];
	logic [7:0]   record_bytes[$];

	parse_state_t pstate = ST_TYPE;
	int           nbytes = 0;
	logic [63:0]  acc = '0;
	logic [63:0]  ref_base = '0, log_base = '0, time_base = '0;
	logic [63:0]  delta_ref = '0, delta_log = '0, delta_time = '0;
	bit           skipping = 1'b0;

	int planned_items = 1;
	int accepted_count = 0;
	int records_sent = 0;
	int samples_seen = 0, end_ok_seen = 0, errors_seen = 0;
	int error_count = 0;
	int cycle_count = 0;

	sample_record_delta_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic out_item_t make_result(logic [2:0] k, logic [63:0] r, logic [63:0] l,
			logic [63:0] t, logic [63:0] v);
		out_item_t o;
		o.kind = k;
		o.series_ref = r;
		o.log_id = l;
		o.timestamp = t;
		o.value_bits = v;
		o.last_of_item = 1'b0;
		return o;
	endfunction

	task automatic decode_byte(input in_item_t it);
		out_item_t   produced[$];
		logic [7:0]  b;
		logic        e;
		logic [63:0] w;
		logic [63:0] d;
		parse_state_t cur;
		bit          failed;
		logic [2:0]  fail_kind;
		b = it.data_byte;
		e = it.end_of_record;
		failed = 1'b0;
		fail_kind = KIND_TRUNC;
		if (skipping) begin
			if (e) begin
				skipping = 1'b0;
				pstate = ST_TYPE;
			end
			return;
		end
		case (pstate)
			ST_TYPE: begin
				if (b != SAMPLES_TYPE) begin
					failed = 1'b1;
					fail_kind = KIND_BAD_TYPE;
				end else if (e) begin
					produced.push_back(make_result(KIND_END_OK, '0, '0, '0, '0));
				end else begin
					pstate = ST_BASE_REF;
					nbytes = 0;
					acc = '0;
				end
			end
			ST_DREF, ST_DLOG, ST_DTIME: begin
				if (nbytes >= 9 && b[7]) begin
					failed = 1'b1;
					fail_kind = KIND_OVERFLOW;
				end else begin
					acc = acc | (64'(b[6:0]) << (7 * (nbytes % 10)));
					if (b[7]) begin
						nbytes++;
					end else begin
						d = (acc >> 1) ^ {64{acc[0]}};
						case (pstate)
							ST_DREF: begin
								delta_ref = d;
								pstate = ST_DLOG;
							end
							ST_DLOG: begin
								delta_log = d;
								pstate = ST_DTIME;
							end
							default: begin
								delta_time = d;
								pstate = ST_VAL;
							end
						endcase
						nbytes = 0;
						acc = '0;
					end
					if (e)
						failed = 1'b1;
				end
			end
			default: begin
				acc = {acc[55:0], b};
				nbytes++;
				if (nbytes >= 8) begin
					w = acc;
					cur = pstate;
					nbytes = 0;
					acc = '0;
					case (cur)
						ST_BASE_REF: begin
							ref_base = w;
							pstate = ST_BASE_LOG;
						end
						ST_BASE_LOG: begin
							log_base = w;
							pstate = ST_BASE_TIME;
						end
						ST_BASE_TIME: begin
							time_base = w;
							pstate = ST_BASE_VAL;
						end
						ST_BASE_VAL: begin
							produced.push_back(make_result(KIND_SAMPLE, ref_base, log_base,
								time_base, w));
							pstate = ST_DREF;
						end
						default: begin
							produced.push_back(make_result(KIND_SAMPLE, ref_base + delta_ref,
								log_base + delta_log, time_base + delta_time, w));
							pstate = ST_DREF;
						end
					endcase
					if (e) begin
						if (cur == ST_BASE_VAL || cur == ST_VAL) begin
							produced.push_back(make_result(KIND_END_OK, '0, '0, '0, '0));
							pstate = ST_TYPE;
						end else begin
							failed = 1'b1;
						end
					end
				end else if (e) begin
					failed = 1'b1;
				end
			end
		endcase
		if (failed) begin
			produced.push_back(make_result(fail_kind, '0, '0, '0, '0));
			pstate = ST_TYPE;
			nbytes = 0;
			acc = '0;
			skipping = !e;
		end
		if (produced.size() != 0)
			produced[produced.size() - 1].last_of_item = 1'b1;
		foreach (produced[i])
			expected_results.push_back(produced[i]);
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			error_count++;
		end
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: result kind %0d with nothing expected, expected none actual %h",
				$time, got.kind, got);
			error_count++;
			return;
		end
		want = expected_results.pop_front();
		compare_field("kind", 64'(want.kind), 64'(got.kind));
		compare_field("series_ref", want.series_ref, got.series_ref);
		compare_field("log_id", want.log_id, got.log_id);
		compare_field("timestamp", want.timestamp, got.timestamp);
		compare_field("value_bits", want.value_bits, got.value_bits);
		compare_field("last_of_item", 64'(want.last_of_item), 64'(got.last_of_item));
		if (want.kind == KIND_SAMPLE)
			samples_seen++;
		else if (want.kind == KIND_END_OK)
			end_ok_seen++;
		else
			errors_seen++;
	endtask

	function automatic int load_mode(int n);
		int m;
		m = n * 4 / planned_items;
		return (m > 3) ? 3 : m;
	endfunction

	function automatic int send_gap_pct(int n);
		case (load_mode(n))
			1: return 65;
			3: return 20;
			default: return 0;
		endcase
	endfunction

	function automatic int pop_stall_pct(int n);
		case (load_mode(n))
			2: return 65;
			3: return 20;
			default: return 0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive
		bit send;
		if (!arst_n) begin
			push <= 1'b0;
			item <= '0;
		end else begin
			if (push && !full) begin
				decode_byte(item);
				void'(pending_items.pop_front());
				accepted_count <= accepted_count + 1;
			end
			if (push && full)
				send = 1'b1;
			else
				send = pending_items.size() != 0 &&
					$urandom_range(0, 99) >= send_gap_pct(accepted_count);
			push <= send;
			if (send)
				item <= pending_items[0];
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				check_result(result);
			pop <= $urandom_range(0, 99) >= pop_stall_pct(accepted_count);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d items pending and %0d results expected",
				$time, pending_items.size(), expected_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			3: return 64'h7fff_ffff_ffff_ffff;
			4: return 64'($urandom_range(0, 255));
			default: return rand64();
		endcase
	endfunction

	function automatic logic [63:0] pick_zigzag_delta();
		logic [63:0] d;
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 7))
			0: d = '0;
			1: d = '1;
			2: d = 64'h8000_0000_0000_0000;
			3: d = 64'h7fff_ffff_ffff_ffff;
			4, 5: d = {{56{r[7]}}, r[7:0]};
			6: d = {{32{r[31]}}, r};
			default: d = rand64();
		endcase
		return (d << 1) ^ {64{d[63]}};
	endfunction

	task automatic add_item(input logic [7:0] b, input logic e);
		in_item_t it;
		it.data_byte = b;
		it.end_of_record = e;
		pending_items.push_back(it);
	endtask

	task automatic append_word(input logic [63:0] w);
		for (int i = 7; i >= 0; i--)
			record_bytes.push_back(w[8 * i +: 8]);
	endtask

	task automatic append_varint(input logic [63:0] u);
		int          groups;
		int          len;
		logic [63:0] rest;
		logic [7:0]  g;
		groups = 1;
		rest = u >> 7;
		while (rest != 0) begin
			groups++;
			rest = rest >> 7;
		end
		case ($urandom_range(0, 9))
			0, 1: len = $urandom_range(1, 10);
			2: len = 10;
			default: len = 1;
		endcase
		if (len < groups)
			len = groups;
		for (int i = 0; i < len; i++) begin
			if (i == 9)
				g = {1'b0, 6'($urandom), u[63]};
			else
				g = {i < len - 1, 7'(u >> (7 * i))};
			record_bytes.push_back(g);
		end
	endtask

	task automatic append_samples(input int deltas);
		record_bytes.push_back(SAMPLES_TYPE);
		for (int i = 0; i < 4; i++)
			append_word(pick_word());
		for (int i = 0; i < deltas; i++) begin
			for (int j = 0; j < 3; j++)
				append_varint(pick_zigzag_delta());
			append_word(pick_word());
		end
	endtask

	task automatic emit_record(input int cut);
		for (int i = 0; i <= cut; i++)
			add_item(record_bytes[i], i == cut);
		record_bytes.delete();
		records_sent++;
	endtask

	initial begin
		int       r;
		int       n;
		bit [7:0] b;

		// type byte alone, bad types with and without end mark, cut after type
		add_item(SAMPLES_TYPE, 1'b1);
		add_item(8'h00, 1'b0);
		add_item(8'h55, 1'b0);
		add_item(8'haa, 1'b1);
		add_item(8'hff, 1'b1);
		add_item(8'h03, 1'b1);
		add_item(8'h82, 1'b1);
		add_item(SAMPLES_TYPE, 1'b0);
		add_item(8'h11, 1'b0);
		add_item(8'h22, 1'b1);
		add_item(SAMPLES_TYPE, 1'b1);
		records_sent = 8;

		while (pending_items.size() < RANDOM_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				record_bytes.push_back(SAMPLES_TYPE);
				emit_record(0);
			end else if (r < 60) begin
				append_samples($urandom_range(0, 3));
				emit_record(record_bytes.size() - 1);
			end else if (r < 75) begin
				append_samples($urandom_range(0, 2));
				emit_record($urandom_range(0, record_bytes.size() - 2));
			end else if (r < 85) begin
				append_samples($urandom_range(0, 1));
				n = $urandom_range(0, 2);
				for (int i = 0; i < n; i++)
					append_varint(pick_zigzag_delta());
				for (int i = 0; i < 10; i++)
					record_bytes.push_back(8'h80 | 8'($urandom));
				if ($urandom_range(0, 1) == 0) begin
					n = $urandom_range(0, 4);
					for (int i = 0; i < n; i++)
						record_bytes.push_back(8'($urandom));
				end
				emit_record(record_bytes.size() - 1);
			end else if (r < 93) begin
				do
					b = 8'($urandom);
				while (b == SAMPLES_TYPE);
				record_bytes.push_back(b);
				n = $urandom_range(0, 5);
				for (int i = 0; i < n; i++)
					record_bytes.push_back(8'($urandom));
				emit_record(record_bytes.size() - 1);
			end else begin
				n = $urandom_range(1, 10);
				for (int i = 0; i < n; i++)
					add_item(8'($urandom), i == n - 1 || $urandom_range(0, 3) == 0);
				records_sent++;
			end
		end
		planned_items = pending_items.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || expected_results.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);

		if (expected_results.size() != 0) begin
			$display("%0t: %0d results never arrived, expected kind %0d actual none",
				$time, expected_results.size(), expected_results[0].kind);
			error_count++;
		end
		$display("%0d bytes in about %0d records sent through four idle/stall phases",
			planned_items, records_sent);
		$display("checked %0d samples, %0d end-ok and %0d error results; %0d mismatches",
			samples_seen, end_ok_seen, errors_seen, error_count);
		if (error_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/srdd_pkg.sv
rtl/srdd_front.sv
rtl/srdd_cmd_queue.sv
rtl/srdd_back.sv
rtl/sample_record_delta_decoder.sv
dv/testbench.sv
